// ===== rtl/bmma_pkg.sv =====
// Shared types and constants for the block matrix multiply-accumulate engine.
// Depends on nothing; every other file of the block imports it.
package bmma_pkg;

  localparam int WORD_W = 32;
  localparam int DIM_W  = 5;
  localparam int IDX_W  = 4;
  localparam int CMD_W  = 3;

  // Command codes carried by an input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 3'd0,
    CMD_WRITE_B = 3'd1,
    CMD_WRITE_C = 3'd2,
    CMD_MAC     = 3'd3,
    CMD_READ_C  = 3'd4
  } cmd_e;

  // Result kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Matrix select bit on the shared A/B memory address.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  // Tag that travels alongside one multiply step through the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

// ===== rtl/bmma_ab_mem.sv =====
// Shared storage for matrices A and B: one write port, two registered read ports.
// Depends on bmma_pkg for the word width.
module bmma_ab_mem #(
  parameter int AW = 8
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW:0]               wr_addr_i,
  input  logic [bmma_pkg::WORD_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW:0]               rd_addr_a_i,
  input  logic [AW:0]               rd_addr_b_i,
  output logic [bmma_pkg::WORD_W-1:0] rd_data_a_o,
  output logic [bmma_pkg::WORD_W-1:0] rd_data_b_o
);
  import bmma_pkg::*;

  logic [WORD_W-1:0] mem_q [2**(AW+1)];
  logic [WORD_W-1:0] rd_a_q;
  logic [WORD_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== rtl/bmma_c_mem.sv =====
// Storage for the accumulator matrix C: one write port, one registered read port.
// Depends on bmma_pkg for the word width.
module bmma_c_mem #(
  parameter int AW = 8
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [bmma_pkg::WORD_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [bmma_pkg::WORD_W-1:0] rd_data_o
);
  import bmma_pkg::*;

  logic [WORD_W-1:0] mem_q [2**AW];
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/bmma_mac.sv =====
// Multiply-accumulate datapath: product register, accumulator and C write-back.
// Depends on bmma_pkg for the word width and the pipeline tag type.
module bmma_mac #(
  parameter int AW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bmma_pkg::mac_tag_t          iss_tag_i,
  input  logic [AW-1:0]               iss_caddr_i,
  input  logic [bmma_pkg::WORD_W-1:0] a_i,
  input  logic [bmma_pkg::WORD_W-1:0] b_i,
  input  logic [bmma_pkg::WORD_W-1:0] c_i,
  output logic                        busy_o,
  output logic                        wb_valid_o,
  output logic [AW-1:0]               wb_addr_o,
  output logic [bmma_pkg::WORD_W-1:0] wb_data_o
);
  import bmma_pkg::*;

  mac_tag_t          s1_tag_q;
  mac_tag_t          s2_tag_q;
  logic [AW-1:0]     s1_addr_q;
  logic [AW-1:0]     s2_addr_q;
  logic [WORD_W-1:0] prod_d;
  logic [WORD_W-1:0] prod_q;
  logic [WORD_W-1:0] cbase_q;
  logic [WORD_W-1:0] acc_q;
  logic [WORD_W-1:0] sum_d;

  // Only the low word of the product is kept; sums wrap.
  assign prod_d = a_i * b_i;
  assign sum_d  = (s2_tag_q.first ? cbase_q : acc_q) + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
    end else begin
      s1_tag_q <= iss_tag_i;
      s2_tag_q <= s1_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= iss_caddr_i;
    s2_addr_q <= s1_addr_q;
    if (s1_tag_q.valid) begin
      prod_q <= prod_d;
      if (s1_tag_q.first) begin
        cbase_q <= c_i;
      end
    end
    if (s2_tag_q.valid) begin
      acc_q <= sum_d;
    end
  end

  assign busy_o     = s1_tag_q.valid | s2_tag_q.valid;
  assign wb_valid_o = s2_tag_q.valid & s2_tag_q.last;
  assign wb_addr_o  = s2_addr_q;
  assign wb_data_o  = sum_d;

endmodule

// ===== rtl/block_matrix_multiply_accumulate.sv =====
// Top level of the block matrix multiply-accumulate engine: sequencer and port logic.
// Depends on bmma_pkg, bmma_ab_mem, bmma_c_mem and bmma_mac.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+-------------------------------------
//   in       | input     | in_valid_i/in_ready_o  | command, row, column, element value
//   out      | output    | out_valid_o/out_ready_i| result kind, result value
//   cfg      | input     | cfg_valid_i/cfg_ready_o| active dimension (5 bits)
//
// An in-range write of A, B or C goes straight into its memory. A read of C passes
// through the registered memory read and then the output register. A multiply-accumulate
// pass over an n x n corner issues n*n*n multiplies, one per cycle through the
// single read port pair of the A/B memory, followed by pipeline drain and done hand-off.
// After reset the C memory is cleared one word per cycle over its
// 2**(2*clog2(MAX_DIMENSION)) words (256 at the default); no input word is
// taken meanwhile, while configuration writes are always taken. A stalled output
// lets writes through until the next read or pass is taken; that word then holds
// the input off until the output register frees.
module block_matrix_multiply_accumulate #(
  parameter int MAX_DIMENSION = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bmma_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bmma_pkg::CMD_W-1:0]         command_i,
  input  logic [bmma_pkg::IDX_W-1:0]         row_index_i,
  input  logic [bmma_pkg::IDX_W-1:0]         column_index_i,
  input  logic signed [bmma_pkg::WORD_W-1:0] element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               result_kind_o,
  output logic signed [bmma_pkg::WORD_W-1:0] result_value_o
);
  import bmma_pkg::*;

  // Index width per dimension, address width of one matrix, widths used when
  // saturating the active dimension, and the width for range-checking input indexes.
  localparam int IW = $clog2(MAX_DIMENSION);
  localparam int AW = 2 * IW;
  localparam int NW = $clog2(MAX_DIMENSION + 1);
  localparam int CW = (NW > DIM_W) ? NW : DIM_W;
  localparam int XW = IW + IDX_W;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [IW-1:0]     r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IW-1:0]     nm1_q, nm1_d;
  logic [DIM_W-1:0]  dim_q;
  logic              rd_pend_q, rd_pend_d;
  logic              rd_zero_q, rd_zero_d;
  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [WORD_W-1:0] out_value_q, out_value_d;

  logic [XW-1:0]     row_ext, col_ext;
  logic [IW-1:0]     row_idx, col_idx;
  logic              in_range;
  logic              in_acc;
  logic              issue;
  logic [CW-1:0]     dim_ext, max_ext, n_eff, nm1_full;

  logic              ab_we;
  logic              ab_sel;
  logic              c_in_we;
  logic              rd_acc;
  logic              mac_start;
  logic              out_free;
  logic              load_rd, load_done;

  logic              c_we;
  logic [AW-1:0]     c_waddr;
  logic [WORD_W-1:0] c_wdata;
  logic              c_re;
  logic [AW-1:0]     c_raddr;
  logic [WORD_W-1:0] c_rdata;
  logic [WORD_W-1:0] a_rdata, b_rdata;

  mac_tag_t          iss_tag;
  logic              mac_busy;
  logic              wb_valid;
  logic [AW-1:0]     wb_addr;
  logic [WORD_W-1:0] wb_data;

  // Input indexes are brought to the internal index width; anything at or beyond
  // MAX_DIMENSION is out of range: it is never written, and a read of it returns zero.
  assign row_ext  = {{IW{1'b0}}, row_index_i};
  assign col_ext  = {{IW{1'b0}}, column_index_i};
  assign row_idx  = row_ext[IW-1:0];
  assign col_idx  = col_ext[IW-1:0];
  assign in_range = (row_ext < XW'(MAX_DIMENSION)) && (col_ext < XW'(MAX_DIMENSION));

  // The active dimension saturates at MAX_DIMENSION.
  assign dim_ext  = CW'(dim_q);
  assign max_ext  = CW'(MAX_DIMENSION);
  assign n_eff    = (dim_ext > max_ext) ? max_ext : dim_ext;
  assign nm1_full = n_eff - CW'(1);

  assign in_ready_o  = (state_q == ST_IDLE) && !rd_pend_q;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign issue       = (state_q == ST_ISSUE);

  // Command decode for an accepted input word.
  always_comb begin
    ab_we     = 1'b0;
    ab_sel    = SEL_A;
    c_in_we   = 1'b0;
    rd_acc    = 1'b0;
    mac_start = 1'b0;
    if (in_acc) begin
      case (command_i)
        CMD_WRITE_A: begin
          ab_we = in_range;
        end
        CMD_WRITE_B: begin
          ab_we  = in_range;
          ab_sel = SEL_B;
        end
        CMD_WRITE_C: begin
          c_in_we = in_range;
        end
        CMD_MAC: begin
          mac_start = 1'b1;
        end
        CMD_READ_C: begin
          rd_acc = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: clearing sweep, idle, the three nested pass loops, drain, done.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    nm1_d   = nm1_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (mac_start) begin
          r_d   = '0;
          c_d   = '0;
          k_d   = '0;
          nm1_d = nm1_full[IW-1:0];
          // An empty corner still reports a finished pass.
          state_d = (n_eff == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == nm1_q) begin
          k_d = '0;
          if (c_q == nm1_q) begin
            c_d = '0;
            if (r_q == nm1_q) begin
              state_d = ST_DRAIN;
            end else begin
              r_d = r_q + IW'(1);
            end
          end else begin
            c_d = c_q + IW'(1);
          end
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded by a pending read or by the end of a pass.
  assign out_free  = !out_valid_q || out_ready_i;
  assign load_rd   = rd_pend_q && out_free;
  assign load_done = (state_q == ST_DONE) && out_free;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    rd_pend_d   = rd_pend_q;
    rd_zero_d   = rd_zero_q;
    if (rd_acc) begin
      rd_pend_d = 1'b1;
      rd_zero_d = !in_range;
    end
    if (load_rd) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_READ;
      out_value_d = rd_zero_q ? '0 : c_rdata;
      rd_pend_d   = 1'b0;
    end else if (load_done) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_DONE;
      out_value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dim_q       <= DIM_RESET;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q         <= r_d;
    c_q         <= c_d;
    k_q         <= k_d;
    nm1_q       <= nm1_d;
    rd_zero_q   <= rd_zero_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
  end

  // C memory ports. The clearing sweep, pass write-back and input writes never
  // overlap, since input words are only taken while idle.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      c_we    = 1'b1;
      c_waddr = clr_q;
      c_wdata = '0;
    end else if (wb_valid) begin
      c_we    = 1'b1;
      c_waddr = wb_addr;
      c_wdata = wb_data;
    end else begin
      c_we    = c_in_we;
      c_waddr = {row_idx, col_idx};
      c_wdata = element_value_i;
    end
  end

  assign c_re    = rd_acc || issue;
  assign c_raddr = issue ? {r_q, c_q} : {row_idx, col_idx};

  assign iss_tag.valid = issue;
  assign iss_tag.first = (k_q == '0);
  assign iss_tag.last  = (k_q == nm1_q);

  bmma_ab_mem #(
    .AW (AW)
  ) u_ab_mem (
    .clk_i       (clk_i),
    .wr_en_i     (ab_we),
    .wr_addr_i   ({ab_sel, row_idx, col_idx}),
    .wr_data_i   (element_value_i),
    .rd_en_i     (issue),
    .rd_addr_a_i ({SEL_A, r_q, k_q}),
    .rd_addr_b_i ({SEL_B, k_q, c_q}),
    .rd_data_a_o (a_rdata),
    .rd_data_b_o (b_rdata)
  );

  bmma_c_mem #(
    .AW (AW)
  ) u_c_mem (
    .clk_i     (clk_i),
    .wr_en_i   (c_we),
    .wr_addr_i (c_waddr),
    .wr_data_i (c_wdata),
    .rd_en_i   (c_re),
    .rd_addr_i (c_raddr),
    .rd_data_o (c_rdata)
  );

  bmma_mac #(
    .AW (AW)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_tag_i   (iss_tag),
    .iss_caddr_i ({r_q, c_q}),
    .a_i         (a_rdata),
    .b_i         (b_rdata),
    .c_i         (c_rdata),
    .busy_o      (mac_busy),
    .wb_valid_o  (wb_valid),
    .wb_addr_o   (wb_addr),
    .wb_data_o   (wb_data)
  );

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign result_value_o = out_value_q;

`ifndef SYNTHESIS
  // A write-back of C happens only while a pass is issuing or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid |-> (state_q == ST_ISSUE) || (state_q == ST_DRAIN))
    else $error("C write-back outside a pass");

  // The done word is only offered once the pipeline has emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !mac_busy)
    else $error("pass reported done with work in flight");

  // A pending read keeps the C read data register from being disturbed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_IDLE) && !c_re)
    else $error("C memory read while a read word is pending");
`endif

endmodule
